@@ sv/spll_pkg.sv @@
// Shared types, constants and register indexes for the shadow pillar light level core.
package spll_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int ANGLE_BITS_DEF = 16;

  localparam int FULL_LEVEL  = 32768;
  localparam int QUARTER_Q15 = 32768;
  localparam int POLY_A      = 51472;
  localparam int POLY_B      = 21023;
  localparam int POLY_C      = 2319;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PILLAR_X        = 3'd0,
    REG_PILLAR_Y        = 3'd1,
    REG_SHADOW_LENGTH   = 3'd2,
    REG_LENGTH_SQ_RECIP = 3'd3,
    REG_START_ANGLE     = 3'd4,
    REG_ROTATION_RATE   = 3'd5,
    REG_FALLOFF_RECIP   = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_BASE = 2'd0,
    MODE_TIP  = 2'd1,
    MODE_MID  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [9:0]  query_x;
    logic [9:0]  query_y;
    logic [31:0] sim_time;
    logic [15:0] light_in;
  } in_word_t;

  typedef struct packed {
    logic [15:0] light_out;
    logic [15:0] pillar_level;
  } out_word_t;

endpackage

@@ sv/spll_sine.sv @@
// Four-stage quarter-wave sine polynomial, two lanes, with a sideband carried alongside.
module spll_sine #(
  parameter int SIDE_W = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [1:0][15:0]   in_z,
  input  logic [SIDE_W-1:0]  in_side,
  output logic               out_vld,
  output logic [1:0][16:0]   out_s,
  output logic [SIDE_W-1:0]  out_side
);

  logic [3:0]              v_r;
  logic [SIDE_W-1:0]       side_r [4];
  logic [1:0][15:0]        z1_r, z2_r, z3_r;
  logic [1:0][16:0]        sq1_r, sq2_r;
  logic [1:0][14:0]        t1_r;
  logic [1:0][15:0]        t2_r;
  logic [1:0][16:0]        s_r;

  logic [1:0][31:0]        m1, m3, m4;
  logic [1:0][28:0]        m2;
  logic [1:0][16:0]        sq1_nxt, s_nxt;
  logic [1:0][14:0]        t1_nxt;
  logic [1:0][15:0]        t2_nxt;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      m1[l]      = in_z[l] * in_z[l];
      sq1_nxt[l] = m1[l][31:15];
      m2[l]      = 12'(spll_pkg::POLY_C) * sq1_r[l];
      t1_nxt[l]  = 15'(spll_pkg::POLY_B) - 15'(m2[l][28:15]);
      m3[l]      = sq2_r[l] * t1_r[l];
      t2_nxt[l]  = 16'(spll_pkg::POLY_A) - 16'(m3[l][31:15]);
      m4[l]      = z3_r[l] * t2_r[l];
      s_nxt[l]   = m4[l][31:15];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    side_r[1] <= side_r[0];
    side_r[2] <= side_r[1];
    side_r[3] <= side_r[2];
    z1_r  <= in_z;
    sq1_r <= sq1_nxt;
    z2_r  <= z1_r;
    sq2_r <= sq1_r;
    t1_r  <= t1_nxt;
    z3_r  <= z2_r;
    t2_r  <= t2_nxt;
    s_r   <= s_nxt;
  end

  assign out_vld  = v_r[3];
  assign out_s    = s_r;
  assign out_side = side_r[3];

endmodule

@@ sv/spll_sqrt.sv @@
// Pipelined floor square root, one root bit per stage.
module spll_sqrt #(
  parameter int RW     = 24,
  parameter int SIDE_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [2*RW-1:0]   in_rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [RW-1:0]     out_root,
  output logic [SIDE_W-1:0] out_side
);

  logic [RW+1:0]     rem_r  [RW];
  logic [RW-1:0]     q_r    [RW];
  logic [2*RW-1:0]   rad_r  [RW];
  logic [SIDE_W-1:0] side_r [RW];
  logic [RW-1:0]     v_r;

  for (genvar k = 0; k < RW; k++) begin : g_st
    logic [RW+1:0]     r_in, r_sh, trial;
    logic [RW-1:0]     q_in;
    logic [2*RW-1:0]   rad_in;
    logic [SIDE_W-1:0] side_in;
    logic              v_in, ge;

    if (k == 0) begin : g_first
      assign r_in    = '0;
      assign q_in    = '0;
      assign rad_in  = in_rad;
      assign side_in = in_side;
      assign v_in    = in_vld;
    end else begin : g_next
      assign r_in    = rem_r[k-1];
      assign q_in    = q_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign side_in = side_r[k-1];
      assign v_in    = v_r[k-1];
    end

    // remainder stays below 2^RW, so its top bits drop out of the shift
    assign r_sh  = {r_in[RW-1:0], rad_in[2*RW-1:2*RW-2]};
    assign trial = {q_in, 2'b01};
    assign ge    = (r_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? (r_sh - trial) : r_sh;
      q_r[k]    <= {q_in[RW-2:0], ge};
      rad_r[k]  <= {rad_in[2*RW-3:0], 2'b00};
      side_r[k] <= side_in;
    end
  end

  assign out_vld  = v_r[RW-1];
  assign out_root = q_r[RW-1];
  assign out_side = side_r[RW-1];

endmodule

@@ sv/shadow_pillar_light_level_core.sv @@
// Shadow pillar light level core: rotating shadow segment, distance, falloff, light product.
// Path from start to out_valid: stage registers, sine unit, root unit; RW = max(COORD_BITS+9, 23) + 2
//   (25 at the default COORD_BITS of 10) is the root width; the root unit gives one bit per stage.
// Throughput: one word per cycle; busy is never raised, every stage advances each clock.
// The receiver cannot stall: out_valid strobes for one cycle per word.
// Reset (synchronous, rst_n low) clears the config registers and the valid bits of every stage.
module shadow_pillar_light_level_core #(
  parameter int COORD_BITS = spll_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = spll_pkg::ANGLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  spll_pkg::in_word_t                   in_data,
  output logic                                 out_valid,
  output spll_pkg::out_word_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [spll_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [spll_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int C    = COORD_BITS;
  localparam int A    = ANGLE_BITS;
  localparam int PXW  = C + 9;                        // query offset, Q.8 cells, signed
  localparam int DW   = 22;                           // segment vector, Q.8 cells, signed
  localparam int DOTW = ((PXW > DW) ? PXW : DW) + DW + 2;
  localparam int EW   = ((PXW > DW + 1) ? PXW : DW + 1) + 1;
  localparam int RW   = EW + 1;                       // root width
  localparam int SSW  = 2 + 2 * PXW + 16;             // sideband through the sine unit

  // ---------------- configuration registers ----------------
  logic [9:0]         pillar_x_r, pillar_y_r;
  logic [19:0]        shadow_length_r;
  logic [23:0]        length_sq_recip_r;
  logic [15:0]        start_angle_r;
  logic signed [23:0] rotation_rate_r;
  logic [23:0]        falloff_recip_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pillar_x_r        <= '0;
      pillar_y_r        <= '0;
      shadow_length_r   <= '0;
      length_sq_recip_r <= '0;
      start_angle_r     <= '0;
      rotation_rate_r   <= '0;
      falloff_recip_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (spll_pkg::cfg_idx_t'(cfg_index))
        spll_pkg::REG_PILLAR_X:        pillar_x_r        <= cfg_data[9:0];
        spll_pkg::REG_PILLAR_Y:        pillar_y_r        <= cfg_data[9:0];
        spll_pkg::REG_SHADOW_LENGTH:   shadow_length_r   <= cfg_data[19:0];
        spll_pkg::REG_LENGTH_SQ_RECIP: length_sq_recip_r <= cfg_data;
        spll_pkg::REG_START_ANGLE:     start_angle_r     <= cfg_data[15:0];
        spll_pkg::REG_ROTATION_RATE:   rotation_rate_r   <= $signed(cfg_data);
        spll_pkg::REG_FALLOFF_RECIP:   falloff_recip_r   <= cfg_data;
        default: ;                     // unknown index: write dropped
      endcase
    end
  end

  // ---------------- stage 1: rotation product, query offset ----------------
  logic [15:0]        qx16, qy16, bx16, by16;
  logic [C-1:0]       qx, qy, bx, by;
  logic signed [C:0]  dqx, dqy;
  logic signed [PXW-1:0] px_nxt, py_nxt;
  logic signed [56:0] prod_nxt;
  logic [15:0]        light_nxt;

  assign qx16 = {6'b0, in_data.query_x};
  assign qy16 = {6'b0, in_data.query_y};
  assign bx16 = {6'b0, pillar_x_r};
  assign by16 = {6'b0, pillar_y_r};
  assign qx   = qx16[C-1:0];
  assign qy   = qy16[C-1:0];
  assign bx   = bx16[C-1:0];
  assign by   = by16[C-1:0];
  assign dqx  = $signed({1'b0, qx}) - $signed({1'b0, bx});
  assign dqy  = $signed({1'b0, qy}) - $signed({1'b0, by});
  assign px_nxt   = {dqx, 8'b0};
  assign py_nxt   = {dqy, 8'b0};
  assign prod_nxt = rotation_rate_r * $signed({1'b0, in_data.sim_time});
  // light above full is taken as full
  assign light_nxt = (in_data.light_in > 16'(spll_pkg::FULL_LEVEL)) ?
                     16'(spll_pkg::FULL_LEVEL) : in_data.light_in;

  logic                  v1_r;
  logic signed [56:0]    prod1_r;
  logic signed [PXW-1:0] px1_r, py1_r;
  logic [15:0]           light1_r;

  // ---------------- stage 2: angle, quarter-turn position ----------------
  logic [23:0]      st24;
  logic [A-1:0]     ang;
  logic [A-3:0]     frac;
  logic [A+12:0]    zw;
  logic [1:0][15:0] zin;
  logic [SSW-1:0]   sin_side_in, sin_side_out;
  logic             sin_vld;
  logic [1:0][16:0] sin_s;

  assign st24   = {8'b0, start_angle_r};
  // angle = floor(rate * time / 2^32) + start, wrapped to one turn
  assign ang    = prod1_r[32+A-1:32] + st24[A-1:0];
  assign frac   = ang[A-3:0];
  assign zw     = {frac, 15'b0} >> (A - 2);
  assign zin[0] = {1'b0, zw[14:0]};
  assign zin[1] = 16'(spll_pkg::QUARTER_Q15) - zin[0];
  assign sin_side_in = {ang[A-1:A-2], px1_r, py1_r, light1_r};

  spll_sine #(.SIDE_W(SSW)) u_sine (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v1_r),
    .in_z     (zin),
    .in_side  (sin_side_in),
    .out_vld  (sin_vld),
    .out_s    (sin_s),
    .out_side (sin_side_out)
  );

  // ---------------- stage 3: quadrant fold, segment vector ----------------
  logic [1:0]            quad;
  logic signed [PXW-1:0] px2, py2;
  logic [15:0]           light2;
  logic signed [17:0]    pz, pc, sn, cs;
  logic signed [38:0]    mdx, mdy;

  assign {quad, px2, py2, light2} = sin_side_out;
  assign pz = $signed({1'b0, sin_s[0]});
  assign pc = $signed({1'b0, sin_s[1]});

  always_comb begin
    case (quad)
      2'd0: begin sn = pz;  cs = pc;  end
      2'd1: begin sn = pc;  cs = -pz; end
      2'd2: begin sn = -pz; cs = -pc; end
      default: begin sn = -pc; cs = pz; end
    endcase
  end

  assign mdx = $signed({1'b0, shadow_length_r}) * cs;
  assign mdy = $signed({1'b0, shadow_length_r}) * sn;

  logic                  v3_r;
  logic signed [DW-1:0]  dx3_r, dy3_r;
  logic signed [PXW-1:0] px3_r, py3_r;
  logic [15:0]           light3_r;

  // ---------------- stage 4: products for projection and length ----------------
  logic                     v4_r;
  logic signed [PXW+DW-1:0] pxdx4_r, pydy4_r;
  logic signed [2*DW-1:0]   dxdx4_r, dydy4_r;
  logic signed [DW-1:0]     dx4_r, dy4_r;
  logic signed [PXW-1:0]    px4_r, py4_r;
  logic [15:0]              light4_r;

  // ---------------- stage 5: dot product and squared length ----------------
  logic signed [DOTW-1:0] dot_nxt, len2_nxt;
  assign dot_nxt  = DOTW'(pxdx4_r) + DOTW'(pydy4_r);
  assign len2_nxt = DOTW'(dxdx4_r) + DOTW'(dydy4_r);

  logic                   v5_r;
  logic signed [DOTW-1:0] dot5_r, len2_5_r;
  logic signed [DW-1:0]   dx5_r, dy5_r;
  logic signed [PXW-1:0]  px5_r, py5_r;
  logic [15:0]            light5_r;

  // ---------------- stage 6: case select, scaled position split in two ----------------
  spll_pkg::mode_t mode_nxt;
  always_comb begin
    if (length_sq_recip_r == '0 || dot5_r < 0) begin
      mode_nxt = spll_pkg::MODE_BASE;       // zero length reciprocal or behind the base
    end else if (dot5_r > len2_5_r) begin
      mode_nxt = spll_pkg::MODE_TIP;        // beyond the tip
    end else begin
      mode_nxt = spll_pkg::MODE_MID;
    end
  end

  logic [47:0] hi_nxt;
  logic [43:0] lo_nxt;
  assign hi_nxt = dot5_r[43:20] * length_sq_recip_r;
  assign lo_nxt = dot5_r[19:0] * length_sq_recip_r;

  logic                  v6_r;
  spll_pkg::mode_t       mode6_r;
  logic [47:0]           hi6_r;
  logic [43:0]           lo6_r;
  logic signed [DW-1:0]  dx6_r, dy6_r;
  logic signed [PXW-1:0] px6_r, py6_r;
  logic [15:0]           light6_r;

  // ---------------- stage 7: position along segment, clamped to one ----------------
  logic [44:0] low_sum;
  logic [44:0] t_sum;
  logic [16:0] t_nxt;
  assign low_sum = {hi6_r[3:0], 20'b0} + 45'(lo6_r);
  assign t_sum   = 45'(hi6_r[47:4]) + 45'(low_sum[44:24]);
  assign t_nxt   = (t_sum > 45'd65536) ? 17'd65536 : t_sum[16:0];

  logic                  v7_r;
  spll_pkg::mode_t       mode7_r;
  logic [16:0]           t7_r;
  logic signed [DW-1:0]  dx7_r, dy7_r;
  logic signed [PXW-1:0] px7_r, py7_r;
  logic [15:0]           light7_r;

  // ---------------- stage 8: closest point products ----------------
  logic signed [39:0] mcx_nxt, mcy_nxt;
  assign mcx_nxt = $signed({1'b0, t7_r}) * dx7_r;
  assign mcy_nxt = $signed({1'b0, t7_r}) * dy7_r;

  logic                  v8_r;
  spll_pkg::mode_t       mode8_r;
  logic signed [39:0]    mcx8_r, mcy8_r;
  logic signed [DW-1:0]  dx8_r, dy8_r;
  logic signed [PXW-1:0] px8_r, py8_r;
  logic [15:0]           light8_r;

  // ---------------- stage 9: closest point select, error vector ----------------
  logic signed [DW:0]   cx, cy;
  logic signed [EW-1:0] ex_nxt, ey_nxt;
  always_comb begin
    case (mode8_r)
      spll_pkg::MODE_TIP: begin
        cx = (DW+1)'(dx8_r); cy = (DW+1)'(dy8_r);
      end
      spll_pkg::MODE_MID: begin
        cx = mcx8_r[16+DW:16];
        cy = mcy8_r[16+DW:16];
      end
      default: begin
        cx = '0; cy = '0;
      end
    endcase
  end
  assign ex_nxt = EW'(px8_r) - EW'(cx);
  assign ey_nxt = EW'(py8_r) - EW'(cy);

  logic                 v9_r;
  logic signed [EW-1:0] ex9_r, ey9_r;
  logic [15:0]          light9_r;

  // ---------------- stage 10: squares ----------------
  logic                   v10_r;
  logic signed [2*EW-1:0] exx10_r, eyy10_r;
  logic [15:0]            light10_r;

  // ---------------- stage 11: squared distance ----------------
  logic [2*RW-1:0] d2_nxt;
  assign d2_nxt = (2*RW)'($unsigned(exx10_r)) + (2*RW)'($unsigned(eyy10_r));

  logic            v11_r;
  logic [2*RW-1:0] d2_11_r;
  logic [15:0]     light11_r;

  // ---------------- root unit ----------------
  logic          sq_vld;
  logic [RW-1:0] distance;
  logic [15:0]   light_sq;

  spll_sqrt #(.RW(RW), .SIDE_W(16)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v11_r),
    .in_rad   (d2_11_r),
    .in_side  (light11_r),
    .out_vld  (sq_vld),
    .out_root (distance),
    .out_side (light_sq)
  );

  // ---------------- stage 12: falloff ----------------
  logic [RW+23:0] lvl_prod;
  assign lvl_prod = distance * falloff_recip_r;

  logic          v12_r;
  logic [RW+10:0] lvl12_r;
  logic [15:0]   light12_r;

  // ---------------- stage 13: clamp, light product ----------------
  logic [15:0] lvl_nxt;
  logic [31:0] lout_prod;
  assign lvl_nxt   = (lvl12_r > (RW+11)'(spll_pkg::FULL_LEVEL)) ?
                     16'(spll_pkg::FULL_LEVEL) : lvl12_r[15:0];
  assign lout_prod = light12_r * lvl_nxt;

  logic                v13_r;
  spll_pkg::out_word_t out_r;

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
      v12_r <= 1'b0;
      v13_r <= 1'b0;
    end else begin
      v1_r  <= start && !busy;
      v3_r  <= sin_vld;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
      v11_r <= v10_r;
      v12_r <= sq_vld;
      v13_r <= v12_r;
    end
  end

  // ---------------- payload ----------------
  always_ff @(posedge clk) begin
    prod1_r  <= prod_nxt;
    px1_r    <= px_nxt;
    py1_r    <= py_nxt;
    light1_r <= light_nxt;

    dx3_r    <= mdx[15+DW-1:15];
    dy3_r    <= mdy[15+DW-1:15];
    px3_r    <= px2;
    py3_r    <= py2;
    light3_r <= light2;

    pxdx4_r  <= px3_r * dx3_r;
    pydy4_r  <= py3_r * dy3_r;
    dxdx4_r  <= dx3_r * dx3_r;
    dydy4_r  <= dy3_r * dy3_r;
    dx4_r    <= dx3_r;
    dy4_r    <= dy3_r;
    px4_r    <= px3_r;
    py4_r    <= py3_r;
    light4_r <= light3_r;

    dot5_r   <= dot_nxt;
    len2_5_r <= len2_nxt;
    dx5_r    <= dx4_r;
    dy5_r    <= dy4_r;
    px5_r    <= px4_r;
    py5_r    <= py4_r;
    light5_r <= light4_r;

    mode6_r  <= mode_nxt;
    hi6_r    <= hi_nxt;
    lo6_r    <= lo_nxt;
    dx6_r    <= dx5_r;
    dy6_r    <= dy5_r;
    px6_r    <= px5_r;
    py6_r    <= py5_r;
    light6_r <= light5_r;

    mode7_r  <= mode6_r;
    t7_r     <= t_nxt;
    dx7_r    <= dx6_r;
    dy7_r    <= dy6_r;
    px7_r    <= px6_r;
    py7_r    <= py6_r;
    light7_r <= light6_r;

    mode8_r  <= mode7_r;
    mcx8_r   <= mcx_nxt;
    mcy8_r   <= mcy_nxt;
    dx8_r    <= dx7_r;
    dy8_r    <= dy7_r;
    px8_r    <= px7_r;
    py8_r    <= py7_r;
    light8_r <= light7_r;

    ex9_r    <= ex_nxt;
    ey9_r    <= ey_nxt;
    light9_r <= light8_r;

    exx10_r   <= ex9_r * ex9_r;
    eyy10_r   <= ey9_r * ey9_r;
    light10_r <= light9_r;

    d2_11_r   <= d2_nxt;
    light11_r <= light10_r;

    lvl12_r   <= lvl_prod[RW+23:13];
    light12_r <= light_sq;

    out_r.light_out    <= lout_prod[30:15];
    out_r.pillar_level <= lvl_nxt;
  end

  assign out_valid = v13_r;
  assign out_data  = out_r;

endmodule

@@ dv/spll_checker.sv @@
// Light level checker: watches the channels, predicts each result word and compares.
`timescale 1ns / 100ps

module spll_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  spll_pkg::in_word_t              in_data,
  input  logic                            out_valid,
  input  spll_pkg::out_word_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [spll_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spll_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);

  localparam int CB = spll_pkg::COORD_BITS_DEF;
  localparam int AB = spll_pkg::ANGLE_BITS_DEF;

  // shadow register copy
  logic [9:0]  base_x, base_y;
  logic [19:0] shadow_len;
  logic [23:0] len_sq_recip;
  logic [15:0] angle0;
  logic signed [23:0] turn_rate;
  logic [23:0] falloff;

  spll_pkg::out_word_t light_queue[$];

  function automatic longint quarter_wave(longint unsigned z);
    longint unsigned z2, t;
    z2 = (z * z) >> 15;
    t  = spll_pkg::POLY_B - ((spll_pkg::POLY_C * z2) >> 15);
    t  = spll_pkg::POLY_A - ((z2 * t) >> 15);
    return longint'((z * t) >> 15);
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic spll_pkg::out_word_t light_after_pillar(spll_pkg::in_word_t w);
    longint qx, qy, bx, by, prod, pz, pc, sn, cs, len, dx, dy, px, py;
    longint dot, len2, cx, cy, ex, ey;
    longint unsigned ang, frac, z, ud, hi, lo, t, d2, distance, lvl, lin;
    logic [63:0] prod_bits;
    spll_pkg::out_word_t r;
    qx = longint'(w.query_x & ((1 << CB) - 1));
    qy = longint'(w.query_y & ((1 << CB) - 1));
    bx = longint'(base_x);
    by = longint'(base_y);
    prod = longint'(turn_rate) * longint'({32'd0, w.sim_time});
    prod_bits = prod;
    ang  = ((prod_bits >> 32) + angle0) & ((64'd1 << AB) - 1);
    frac = ang & ((64'd1 << (AB - 2)) - 1);
    z    = (frac << 15) >> (AB - 2);
    pz = quarter_wave(z);
    pc = quarter_wave(spll_pkg::QUARTER_Q15 - z);
    case (ang >> (AB - 2))
      0:       begin sn = pz;  cs = pc;  end
      1:       begin sn = pc;  cs = -pz; end
      2:       begin sn = -pz; cs = -pc; end
      default: begin sn = -pc; cs = pz;  end
    endcase
    len = longint'(shadow_len);
    dx = (len * cs) >>> 15;
    dy = (len * sn) >>> 15;
    px = (qx - bx) * 256;
    py = (qy - by) * 256;
    dot  = px * dx + py * dy;
    len2 = dx * dx + dy * dy;
    if (len_sq_recip == 0 || dot < 0) begin
      // base is closest: behind it or zero length reciprocal
      cx = 0; cy = 0;
    end else if (dot > len2) begin
      cx = dx; cy = dy;
    end else begin
      ud = dot;
      hi = (ud >> 20) * len_sq_recip;
      lo = (ud & 64'hFFFFF) * len_sq_recip;
      t  = (hi >> 4) + ((((hi & 15) << 20) + lo) >> 24);
      if (t > 65536) t = 65536;
      cx = (longint'(t) * dx) >>> 16;
      cy = (longint'(t) * dy) >>> 16;
    end
    ex = px - cx;
    ey = py - cy;
    d2 = longint'(ex * ex) + longint'(ey * ey);
    distance = isqrt(d2);
    lvl = (distance * falloff) >> 13;
    if (lvl > spll_pkg::FULL_LEVEL) lvl = spll_pkg::FULL_LEVEL;
    lin = w.light_in;
    if (lin > spll_pkg::FULL_LEVEL) lin = spll_pkg::FULL_LEVEL;
    r.light_out    = 16'((lin * lvl) >> 15);
    r.pillar_level = 16'(lvl);
    return r;
  endfunction

  assign pending = light_queue.size();

  always @(posedge clk) begin
    spll_pkg::out_word_t exp_w;
    if (!rst_n) begin
      base_x <= '0; base_y <= '0; shadow_len <= '0; len_sq_recip <= '0;
      angle0 <= '0; turn_rate <= '0; falloff <= '0;
      light_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (spll_pkg::cfg_idx_t'(cfg_index))
          spll_pkg::REG_PILLAR_X:        base_x       <= cfg_data[9:0];
          spll_pkg::REG_PILLAR_Y:        base_y       <= cfg_data[9:0];
          spll_pkg::REG_SHADOW_LENGTH:   shadow_len   <= cfg_data[19:0];
          spll_pkg::REG_LENGTH_SQ_RECIP: len_sq_recip <= cfg_data;
          spll_pkg::REG_START_ANGLE:     angle0       <= cfg_data[15:0];
          spll_pkg::REG_ROTATION_RATE:   turn_rate    <= cfg_data;
          spll_pkg::REG_FALLOFF_RECIP:   falloff      <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy)
        light_queue.insert(light_queue.size(), light_after_pillar(in_data));
      if (out_valid) begin
        if (light_queue.size() == 0) begin
          $display("%0t: unexpected word %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = light_queue.pop_front();
          if (exp_w.light_out !== out_data.light_out) begin
            $display("%0t: light_out expected %0d actual %0d", $time,
                     exp_w.light_out, out_data.light_out);
            fail_count <= fail_count + 1;
          end else if (exp_w.pillar_level !== out_data.pillar_level) begin
            $display("%0t: pillar_level expected %0d actual %0d", $time,
                     exp_w.pillar_level, out_data.pillar_level);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ dv/testbench.sv @@
// Top of the light level bench: clock, reset, config phases, query stimulus, verdict.
`timescale 1ns / 100ps

module testbench;

  localparam int LATENCY     = 45;       // margin above the core pipeline depth at default params
  localparam int CYCLE_LIMIT = 300000;   // far above the slowest legal run
  localparam logic [spll_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  spll_pkg::in_word_t in_data = '0;
  logic out_valid;
  spll_pkg::out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [spll_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [spll_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  int fail_count, pending;
  int cycles = 0;

  always #5 clk = ~clk;

  shadow_pillar_light_level_core dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  spll_checker chk (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .pending
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // cfg_valid is dropped and the task idles after each write, so each write lands once
  task automatic write_reg(logic [spll_pkg::CFG_IDX_W-1:0] idx,
                           logic [spll_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drain everything in flight so config writes land on an idle core
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // start stays high across back-to-back words; caller drops it for gaps
  task automatic send_word(spll_pkg::in_word_t w);
    start   <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic load_pillar(int bx, int by, int len, int recip, int ang, int rate,
                             int fall);
    write_reg(spll_pkg::REG_PILLAR_X, 24'(bx));
    write_reg(spll_pkg::REG_PILLAR_Y, 24'(by));
    write_reg(spll_pkg::REG_SHADOW_LENGTH, 24'(len));
    write_reg(spll_pkg::REG_LENGTH_SQ_RECIP, 24'(recip));
    write_reg(spll_pkg::REG_START_ANGLE, 24'(ang));
    write_reg(spll_pkg::REG_ROTATION_RATE, 24'(rate));
    write_reg(spll_pkg::REG_FALLOFF_RECIP, 24'(fall));
  endtask

  function automatic spll_pkg::in_word_t mk_word(int qx, int qy, int unsigned tm, int lin);
    spll_pkg::in_word_t w;
    w.query_x  = 10'(qx);
    w.query_y  = 10'(qy);
    w.sim_time = tm;
    w.light_in = 16'(lin);
    return w;
  endfunction

  // matched 1/L^2 in Q0.24 for L in Q12.8 cells
  function automatic int recip_for(int len);
    longint q;
    if (len == 0) return 0;
    q = (64'd1 << 40) / (longint'(len) * len);
    return (q > 24'hFFFFFF) ? 24'hFFFFFF : int'(q);
  endfunction

  function automatic spll_pkg::in_word_t rand_word(int bx, int by);
    spll_pkg::in_word_t w;
    int lin;
    w = mk_word($urandom_range(1023), $urandom_range(1023), $urandom(), 0);
    // most queries land near the pillar so the segment math matters
    if ($urandom_range(3) != 0) begin
      w.query_x = 10'(bx + $urandom_range(80) - 40);
      w.query_y = 10'(by + $urandom_range(80) - 40);
    end
    case ($urandom_range(9))
      0:       lin = $urandom_range(65535);   // above full light too
      1:       lin = spll_pkg::FULL_LEVEL;
      default: lin = $urandom_range(spll_pkg::FULL_LEVEL);
    endcase
    w.light_in = 16'(lin);
    return w;
  endfunction

  initial begin
    int bx, by, len, n_burst, sent;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: pillar at center, 10-cell shadow along +x, still
    load_pillar(512, 512, 2560, recip_for(2560), 0, 0, 10486);
    send_word(mk_word(520, 515, 0, spll_pkg::FULL_LEVEL));      // mid segment
    send_word(mk_word(530, 512, 0, spll_pkg::FULL_LEVEL));      // beyond the tip
    send_word(mk_word(500, 512, 0, spll_pkg::FULL_LEVEL));      // behind the base
    send_word(mk_word(0, 0, 32'hFFFFFFFF, 0));
    send_word(mk_word(1023, 1023, 0, 16'hFFFF));                // light above full
    send_word(mk_word(1023, 0, 32'h8000_0000, 1));
    send_word(mk_word(515, 512, 0, 16'h7FFF));                  // on the shadow itself
    drain();
    // zero-length shadow, max falloff, fast negative turn
    load_pillar(1023, 0, 0, 0, 16'hFFFF, -8388608, 24'hFFFFFF);
    write_reg(REG_UNMAPPED, 24'hFFFFFF);                        // must be ignored
    send_word(mk_word(1023, 0, 32'h0001_0000, spll_pkg::FULL_LEVEL));
    send_word(mk_word(1000, 20, 32'hFFFFFFFF, spll_pkg::FULL_LEVEL));
    send_word(mk_word(0, 1023, 32'h1234_5678, 20000));
    drain();
    // longest shadow, max recip, max positive turn, zero falloff
    load_pillar(0, 1023, 20'hFFFFF, 24'hFFFFFF, 16'h4000, 8388607, 0);
    send_word(mk_word(100, 900, 32'h0000_0001, spll_pkg::FULL_LEVEL));
    send_word(mk_word(1023, 1023, 32'hFFFF_0000, spll_pkg::FULL_LEVEL));
    drain();

    // random phases, each with a fresh pillar setting
    for (int ph = 0; ph < 8; ph++) begin
      bx  = $urandom_range(1023);
      by  = $urandom_range(1023);
      len = (ph == 7) ? 20'hFFFFF : $urandom_range(30 * 256);
      load_pillar(bx, by, len,
                  (ph == 3) ? 0 : (ph == 5) ? $urandom_range(24'hFFFFFF) : recip_for(len),
                  $urandom_range(65535),
                  (ph == 1) ? 0 : $signed(24'($urandom())),
                  (ph == 6) ? $urandom_range(24'hFFFFFF) : $urandom_range(65535));
      sent = 0;
      while (sent < 190) begin
        n_burst = (ph == 2) ? 190 : $urandom_range(1, 24);   // one long unbroken run
        for (int k = 0; k < n_burst && sent < 190; k++, sent++)
          send_word(rand_word(bx, by));
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ shadow_pillar_light_level_core.f @@
sv/spll_pkg.sv
sv/spll_sine.sv
sv/spll_sqrt.sv
sv/shadow_pillar_light_level_core.sv
dv/spll_checker.sv
dv/testbench.sv
